/* rtl/rv32im_instruction_execute_unit_macros.svh */
// assertion macros for the rv32im instruction execute unit
`ifndef RV32IM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RV32IM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define RVIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rvie_pkg.sv */
// shared types and constants of the rv32im instruction execute unit
`timescale 1ns / 1ps
`default_nettype none

package rvie_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EBREAK  = 3'd1,
        ST_INVALID = 3'd2,
        ST_BAD_CSR = 3'd3,
        ST_STOPPED = 3'd4
    } t_status;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INSTR_MRET   = 32'h3020_0073;

    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;

    localparam logic [31:0] CAUSE_ECALL = 32'd11;
    localparam logic [31:0] START_RESET = 32'h8000_0000;
    localparam logic [4:0]  REG_A0      = 5'd10;

    typedef enum logic [2:0] {
        K_WB,
        K_MUL,
        K_DIV,
        K_LOAD,
        K_STORE,
        K_HALT
    } t_kind;

endpackage

`default_nettype wire

/* rtl/rv32im_instruction_execute_unit.sv */
// rv32im instruction execute unit: multicycle core around register file and data memory
`timescale 1ns / 1ps
`default_nettype none

// Executes one RV32IM instruction word per request at the kept program counter and returns
// one result per request. After reset a clearing pass zeroes the data memory, during which
// o_stall is high. Plain instructions pass through accept, register file read, execute and
// writeback; multiplies add a finishing step and ebreak a step that reads a0; divides and
// remainders run the 32-step iterative divider. Loads and stores reduce their address
// modulo MEM_BYTES by a reciprocal multiply, a multiply back and one correcting subtract,
// then move one byte per step through the single memory port: a load takes an address
// step and a data step per byte, a store one step per byte. Once the block is stopped a
// request goes from acceptance straight to writeback. The result is registered at the end
// of writeback and waits in the output register while the next request is taken; writeback
// holds for as long as a previous result is still stalled there.
module rv32im_instruction_execute_unit
    import rvie_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_instruction,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_instr_pc,
    output logic [31:0] o_next_pc,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic        o_dest_write,
    output logic [2:0]  o_status,
    output logic [31:0] o_halt_code
);

    `include "rv32im_instruction_execute_unit_macros.svh"

    localparam int IDXW = $clog2(MEM_BYTES);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MEM_BYTES - 1);
    localparam logic [31:0] MEM_SIZE = 32'(MEM_BYTES);
    localparam logic [31:0] RECIP = 32'((64'd1 << (31 + IDXW)) / 64'(MEM_BYTES));

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_A0, S_MULF, S_DIV, S_DIVF, S_MOD1, S_MOD2,
        S_MEMA, S_MEMD, S_WB
    } t_state;

    t_state r_state;

    logic [31:0] r_start;
    logic [31:0] r_pc;
    logic [31:0] r_mstatus, r_mtvec, r_mepc, r_mcause;
    logic        r_stopped;
    logic [31:0] r_rf_valid;
    logic [IDXW-1:0] r_clr;

    logic [31:0] r_rf [32];
    logic [31:0] r_q1, r_q2;
    logic [7:0]  r_dmem [MEM_BYTES];
    logic [7:0]  r_mem_q;

    logic [31:0] r_instr, r_a, r_b;
    logic [31:0] r_val, r_npc, r_halt;
    logic        r_wr;
    t_status     r_status;
    logic [63:0] r_prod;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [4:0]  r_cnt;
    logic        r_is_mem, r_is_store;
    logic [31:0] r_addr, r_ld;
    logic [IDXW-1:0] r_base, r_prev;
    logic [2:0]  r_k, r_n;

    logic        r_ovalid;
    logic [31:0] r_opc, r_onpc, r_oval, r_ohalt;
    logic [4:0]  r_ord;
    logic        r_owr;
    t_status     r_ostatus;

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_start : 32'd0;

    // decode fields
    logic [6:0]  w_op, w_f7;
    logic [2:0]  w_f3;
    logic [4:0]  w_rd, w_rs1, w_rs2;
    logic [31:0] immi, imms, immb, immj;
    assign w_op  = r_instr[6:0];
    assign w_f3  = r_instr[14:12];
    assign w_f7  = r_instr[31:25];
    assign w_rd  = r_instr[11:7];
    assign w_rs1 = r_instr[19:15];
    assign w_rs2 = r_instr[24:20];
    assign immi = {{20{r_instr[31]}}, r_instr[31:20]};
    assign imms = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};
    assign immb = {{19{r_instr[31]}}, r_instr[31], r_instr[7], r_instr[30:25],
                   r_instr[11:8], 1'b0};
    assign immj = {{11{r_instr[31]}}, r_instr[31], r_instr[19:12], r_instr[20],
                   r_instr[30:21], 1'b0};

    logic [31:0] x_val, x_npc, x_csr_rd, x_csr_wdata;
    logic        x_wr, x_bad, x_badcsr, x_csr_we, x_ecall, x_take;
    logic [1:0]  x_csr_sel;
    t_kind       x_kind;

    always_comb begin
        x_val       = 32'd0;
        x_wr        = 1'b0;
        x_npc       = r_pc + 32'd4;
        x_bad       = 1'b0;
        x_badcsr    = 1'b0;
        x_csr_we    = 1'b0;
        x_csr_wdata = 32'd0;
        x_ecall     = 1'b0;
        x_take      = 1'b0;
        x_kind      = K_WB;
        x_csr_sel   = 2'd0;
        x_csr_rd    = 32'd0;
        case (r_instr[31:20])
            CSR_MSTATUS: begin x_csr_sel = 2'd0; x_csr_rd = r_mstatus; end
            CSR_MTVEC:   begin x_csr_sel = 2'd1; x_csr_rd = r_mtvec; end
            CSR_MEPC:    begin x_csr_sel = 2'd2; x_csr_rd = r_mepc; end
            CSR_MCAUSE:  begin x_csr_sel = 2'd3; x_csr_rd = r_mcause; end
            default:     x_badcsr = 1'b1;
        endcase
        case (w_op)
            OP_LUI: begin
                x_val = {r_instr[31:12], 12'd0};
                x_wr  = 1'b1;
            end
            OP_AUIPC: begin
                x_val = r_pc + {r_instr[31:12], 12'd0};
                x_wr  = 1'b1;
            end
            OP_JAL: begin
                x_val = r_pc + 32'd4;
                x_wr  = 1'b1;
                x_npc = r_pc + immj;
            end
            OP_JALR: begin
                if (w_f3 != 3'd0) begin
                    x_bad = 1'b1;
                end else begin
                    x_val = r_pc + 32'd4;
                    x_wr  = 1'b1;
                    x_npc = (r_a + immi) & ~32'd1;
                end
            end
            OP_BRANCH: begin
                case (w_f3)
                    3'd0: x_take = (r_a == r_b);
                    3'd1: x_take = (r_a != r_b);
                    3'd4: x_take = ($signed(r_a) < $signed(r_b));
                    3'd5: x_take = !($signed(r_a) < $signed(r_b));
                    3'd6: x_take = (r_a < r_b);
                    3'd7: x_take = (r_a >= r_b);
                    default: x_bad = 1'b1;
                endcase
                if (x_take) x_npc = r_pc + immb;
            end
            OP_LOAD: begin
                if (w_f3 == 3'd3 || w_f3 == 3'd6 || w_f3 == 3'd7) begin
                    x_bad = 1'b1;
                end else begin
                    x_wr   = 1'b1;
                    x_kind = K_LOAD;
                end
            end
            OP_STORE: begin
                if (w_f3 > 3'd2) x_bad = 1'b1;
                else x_kind = K_STORE;
            end
            OP_IMM: begin
                x_wr = 1'b1;
                case (w_f3)
                    3'd0: x_val = r_a + immi;
                    3'd2: x_val = {31'd0, $signed(r_a) < $signed(immi)};
                    3'd3: x_val = {31'd0, r_a < immi};
                    3'd4: x_val = r_a ^ immi;
                    3'd6: x_val = r_a | immi;
                    3'd7: x_val = r_a & immi;
                    3'd1: begin
                        if (w_f7 != F7_BASE) x_bad = 1'b1;
                        else x_val = r_a << w_rs2;
                    end
                    default: begin
                        if (w_f7 == F7_BASE) x_val = r_a >> w_rs2;
                        else if (w_f7 == F7_ALT) x_val = 32'($signed(r_a) >>> w_rs2);
                        else x_bad = 1'b1;
                    end
                endcase
            end
            OP_REG: begin
                x_wr = 1'b1;
                if (w_f7 == F7_BASE) begin
                    case (w_f3)
                        3'd0: x_val = r_a + r_b;
                        3'd1: x_val = r_a << r_b[4:0];
                        3'd2: x_val = {31'd0, $signed(r_a) < $signed(r_b)};
                        3'd3: x_val = {31'd0, r_a < r_b};
                        3'd4: x_val = r_a ^ r_b;
                        3'd5: x_val = r_a >> r_b[4:0];
                        3'd6: x_val = r_a | r_b;
                        default: x_val = r_a & r_b;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    x_val = r_a - r_b;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    x_val = 32'($signed(r_a) >>> r_b[4:0]);
                end else if (w_f7 == F7_MULDIV) begin
                    x_kind = w_f3[2] ? K_DIV : K_MUL;
                end else begin
                    x_bad = 1'b1;
                end
            end
            OP_SYSTEM: begin
                if (w_f3 == 3'd1 || w_f3 == 3'd2) begin
                    if (!x_badcsr) begin
                        x_val = x_csr_rd;
                        x_wr  = 1'b1;
                        if (w_f3 == 3'd1) begin
                            x_csr_we    = 1'b1;
                            x_csr_wdata = r_a;
                        end else if (w_rs1 != 5'd0) begin
                            x_csr_we    = 1'b1;
                            x_csr_wdata = x_csr_rd | r_a;
                        end
                    end
                end else if (r_instr == INSTR_EBREAK) begin
                    x_kind = K_HALT;
                end else if (r_instr == INSTR_ECALL) begin
                    x_ecall = 1'b1;
                    x_npc   = r_mtvec;
                end else if (r_instr == INSTR_MRET) begin
                    x_npc = r_mepc;
                end else begin
                    x_bad = 1'b1;
                end
            end
            default: x_bad = 1'b1;
        endcase
        if (!(w_op == OP_SYSTEM && (w_f3 == 3'd1 || w_f3 == 3'd2))) x_badcsr = 1'b0;
    end

    // divider step
    logic [32:0] d_sh, d_diff;
    assign d_sh   = {r_rem, r_quo[31]};
    assign d_diff = d_sh - {1'b0, r_dvs};

    // address reduction: quotient estimate from the reciprocal, low or one short
    logic [31:0] mod_q, mod_sub;
    assign mod_q   = 32'(r_prod >> (31 + IDXW));
    assign mod_sub = mod_q * MEM_SIZE;

    // byte address of step k
    logic [32:0]     m_sum;
    logic [IDXW-1:0] m_idx;
    always_comb begin
        m_sum = {1'b0, r_addr} + {30'd0, r_k};
        if (m_sum[32]) m_idx = m_sum[IDXW-1:0];
        else if (r_k == 3'd0) m_idx = r_base;
        else if (r_prev == LAST_IDX) m_idx = '0;
        else m_idx = r_prev + 1'b1;
    end

    logic [31:0] ld_full;
    assign ld_full = r_ld | ({24'd0, r_mem_q} << {r_k[1:0], 3'b000});

    logic [31:0] st_word;
    assign st_word = r_b >> {r_k[1:0], 3'b000};

    logic            mem_we;
    logic [IDXW-1:0] mem_widx;
    logic [7:0]      mem_wdata;
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_MEMA && r_is_store);
    assign mem_widx  = (r_state == S_CLEAR) ? r_clr : m_idx;
    assign mem_wdata = (r_state == S_CLEAR) ? 8'd0 : st_word[7:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) r_dmem[mem_widx] <= mem_wdata;
        r_mem_q <= r_dmem[m_idx];
    end

    logic       rf_we;
    logic [4:0] rf_ra1;
    assign rf_we  = (r_state == S_WB) && (!r_ovalid || !i_stall) && r_wr && (w_rd != 5'd0);
    assign rf_ra1 = (r_state == S_EXEC) ? REG_A0 : i_instruction[19:15];

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[w_rd] <= r_val;
        r_q1 <= r_rf[rf_ra1];
        r_q2 <= r_rf[i_instruction[24:20]];
    end

    logic [31:0] a_mag, b_mag, hu;
    assign a_mag = r_a[31] ? (32'd0 - r_a) : r_a;
    assign b_mag = r_b[31] ? (32'd0 - r_b) : r_b;
    assign hu    = r_prod[63:32];

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_start    <= START_RESET;
            r_pc       <= START_RESET;
            r_mstatus  <= 32'd0;
            r_mtvec    <= 32'd0;
            r_mepc     <= 32'd0;
            r_mcause   <= 32'd0;
            r_stopped  <= 1'b0;
            r_rf_valid <= 32'd0;
            r_ovalid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) r_start <= pwdata;
            if (r_ovalid && !i_stall && r_state != S_WB) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_IDX) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_instr <= i_instruction;
                        if (r_stopped) begin
                            r_val    <= 32'd0;
                            r_wr     <= 1'b0;
                            r_npc    <= r_pc;
                            r_halt   <= 32'd0;
                            r_status <= ST_STOPPED;
                            r_state  <= S_WB;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_a <= (w_rs1 != 5'd0 && r_rf_valid[w_rs1]) ? r_q1 : 32'd0;
                    r_b <= (w_rs2 != 5'd0 && r_rf_valid[w_rs2]) ? r_q2 : 32'd0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_halt   <= 32'd0;
                    r_is_mem <= 1'b0;
                    if (x_bad || x_badcsr) begin
                        r_status <= x_bad ? ST_INVALID : ST_BAD_CSR;
                        r_wr     <= 1'b0;
                        r_val    <= 32'd0;
                        r_npc    <= r_pc;
                        r_state  <= S_WB;
                    end else begin
                        r_status <= ST_OK;
                        r_wr     <= x_wr;
                        r_val    <= x_val;
                        r_npc    <= x_npc;
                        if (x_csr_we) begin
                            case (x_csr_sel)
                                2'd0: r_mstatus <= x_csr_wdata;
                                2'd1: r_mtvec   <= x_csr_wdata;
                                2'd2: r_mepc    <= x_csr_wdata;
                                default: r_mcause <= x_csr_wdata;
                            endcase
                        end
                        if (x_ecall) begin
                            r_mepc   <= r_pc;
                            r_mcause <= CAUSE_ECALL;
                        end
                        r_rem <= 32'd0;
                        r_cnt <= 5'd0;
                        case (x_kind)
                            K_MUL: begin
                                r_prod  <= r_a * r_b;
                                r_state <= S_MULF;
                            end
                            K_DIV: begin
                                r_quo   <= w_f3[0] ? r_a : a_mag;
                                r_dvs   <= w_f3[0] ? r_b : b_mag;
                                r_state <= S_DIV;
                            end
                            K_LOAD, K_STORE: begin
                                r_addr     <= r_a + ((x_kind == K_STORE) ? imms : immi);
                                r_is_mem   <= 1'b1;
                                r_is_store <= (x_kind == K_STORE);
                                r_n        <= (w_f3[1:0] == 2'd0) ? 3'd1 :
                                              (w_f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                                r_state    <= S_MOD1;
                            end
                            K_HALT: begin
                                r_status <= ST_EBREAK;
                                r_state  <= S_A0;
                            end
                            default: r_state <= S_WB;
                        endcase
                    end
                end
                S_A0: begin
                    r_halt  <= r_rf_valid[REG_A0] ? r_q1 : 32'd0;
                    r_state <= S_WB;
                end
                S_MULF: begin
                    case (w_f3[1:0])
                        2'd0: r_val <= r_prod[31:0];
                        2'd1: r_val <= hu - (r_a[31] ? r_b : 32'd0) - (r_b[31] ? r_a : 32'd0);
                        2'd2: r_val <= hu - (r_a[31] ? r_b : 32'd0);
                        default: r_val <= hu;
                    endcase
                    r_state <= S_WB;
                end
                S_DIV: begin
                    if (!d_diff[32]) begin
                        r_rem <= d_diff[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= d_sh[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) r_state <= S_DIVF;
                end
                S_MOD1: begin
                    r_prod  <= r_addr * RECIP;
                    r_state <= S_MOD2;
                end
                S_MOD2: begin
                    r_rem   <= r_addr - mod_sub;
                    r_state <= S_DIVF;
                end
                S_DIVF: begin
                    if (r_is_mem) begin
                        r_base  <= (r_rem >= MEM_SIZE) ? IDXW'(r_rem - MEM_SIZE) :
                                                         r_rem[IDXW-1:0];
                        r_k     <= 3'd0;
                        r_ld    <= 32'd0;
                        r_state <= S_MEMA;
                    end else begin
                        case (w_f3[1:0])
                            2'd0: r_val <= (r_b == 32'd0) ? 32'hffff_ffff :
                                           ((r_a[31] ^ r_b[31]) ? (32'd0 - r_quo) : r_quo);
                            2'd1: r_val <= r_quo;
                            2'd2: r_val <= r_a[31] ? (32'd0 - r_rem) : r_rem;
                            default: r_val <= r_rem;
                        endcase
                        r_state <= S_WB;
                    end
                end
                S_MEMA: begin
                    r_prev <= m_idx;
                    if (r_is_store) begin
                        r_k <= r_k + 1'b1;
                        if (r_k + 3'd1 == r_n) r_state <= S_WB;
                    end else begin
                        r_state <= S_MEMD;
                    end
                end
                S_MEMD: begin
                    r_ld <= ld_full;
                    r_k  <= r_k + 1'b1;
                    if (r_k + 3'd1 == r_n) begin
                        case (w_f3)
                            3'd0: r_val <= {{24{ld_full[7]}}, ld_full[7:0]};
                            3'd1: r_val <= {{16{ld_full[15]}}, ld_full[15:0]};
                            3'd4: r_val <= {24'd0, ld_full[7:0]};
                            3'd5: r_val <= {16'd0, ld_full[15:0]};
                            default: r_val <= ld_full;
                        endcase
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_MEMA;
                    end
                end
                S_WB: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_opc     <= r_pc;
                        r_onpc    <= r_npc;
                        r_ostatus <= r_status;
                        r_ohalt   <= r_halt;
                        if (r_wr && w_rd != 5'd0) begin
                            r_ord  <= w_rd;
                            r_oval <= r_val;
                            r_owr  <= 1'b1;
                            r_rf_valid[w_rd] <= 1'b1;
                        end else begin
                            r_ord  <= 5'd0;
                            r_oval <= 32'd0;
                            r_owr  <= 1'b0;
                        end
                        r_pc <= r_npc;
                        if (r_status == ST_EBREAK || r_status == ST_INVALID ||
                            r_status == ST_BAD_CSR) begin
                            r_stopped <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_instr_pc   = r_opc;
    assign o_next_pc    = r_onpc;
    assign o_dest_index = r_ord;
    assign o_dest_value = r_oval;
    assign o_dest_write = r_owr;
    assign o_status     = r_ostatus;
    assign o_halt_code  = r_ohalt;

    `RVIE_ASSERT_NEXT(a_rf_write_valid, rf_we, r_rf_valid[$past(w_rd)], "written register not marked valid")
    `RVIE_ASSERT_NOW(a_stopped_no_store, r_stopped, !(mem_we && r_state != S_CLEAR), "store while stopped")
    `RVIE_ASSERT_NOW(a_fault_holds_pc, r_ovalid && (r_ostatus == ST_INVALID || r_ostatus == ST_BAD_CSR), r_onpc == r_opc, "faulting request moved pc")
    `RVIE_ASSERT_NOW(a_fault_no_write, r_ovalid && r_ostatus != ST_OK, !r_owr || r_ostatus == ST_EBREAK, "faulting request wrote a register")

endmodule

`default_nettype wire
